[rtl/ces_pkg.sv]
package ces_pkg;

  localparam int NUM_COORDS  = 8;
  localparam int COORD_W     = 16;
  localparam int FRAME_W     = 32;
  localparam int HIST_W      = 32;
  localparam int FRAC_SHIFT  = 16;
  localparam int ALPHA_W     = 17;
  localparam int GAP_W       = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 17;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAP    = 2'd2;

  localparam logic                 ENABLE_RST = 1'b1;
  localparam logic [ALPHA_W-1:0]   ALPHA_RST  = 17'd32768;
  localparam logic [ALPHA_W-1:0]   ALPHA_ONE  = 17'd65536;
  localparam logic [GAP_W-1:0]     GAP_RST    = 16'd10;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [HIST_W-1:0]  hist_t;

  typedef enum logic [1:0] {
    MODE_PASS,
    MODE_LOAD,
    MODE_UPDATE
  } mode_t;

  typedef struct packed {
    mode_t                       mode;
    logic                        restarted;
    coord_t [NUM_COORDS-1:0]     coords;
  } entry_t;

  typedef struct packed {
    logic               enable;
    logic [ALPHA_W-1:0] alpha;
    logic [GAP_W-1:0]   gap;
  } cfg_t;

endpackage

[rtl/ces_in_if.sv]
interface ces_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   corners_present;
  logic [ces_pkg::FRAME_W-1:0]            frame_number;
  logic signed [ces_pkg::COORD_W-1:0]     corner_x0;
  logic signed [ces_pkg::COORD_W-1:0]     corner_y0;
  logic signed [ces_pkg::COORD_W-1:0]     corner_x1;
  logic signed [ces_pkg::COORD_W-1:0]     corner_y1;
  logic signed [ces_pkg::COORD_W-1:0]     corner_x2;
  logic signed [ces_pkg::COORD_W-1:0]     corner_y2;
  logic signed [ces_pkg::COORD_W-1:0]     corner_x3;
  logic signed [ces_pkg::COORD_W-1:0]     corner_y3;

  modport source (
    output valid, corners_present, frame_number,
    output corner_x0, corner_y0, corner_x1, corner_y1,
    output corner_x2, corner_y2, corner_x3, corner_y3,
    input  ready
  );

  modport sink (
    input  valid, corners_present, frame_number,
    input  corner_x0, corner_y0, corner_x1, corner_y1,
    input  corner_x2, corner_y2, corner_x3, corner_y3,
    output ready
  );
endinterface

[rtl/ces_out_if.sv]
interface ces_out_if;
  logic                                   valid;
  logic                                   ready;
  logic signed [ces_pkg::COORD_W-1:0]     smoothed_x0;
  logic signed [ces_pkg::COORD_W-1:0]     smoothed_y0;
  logic signed [ces_pkg::COORD_W-1:0]     smoothed_x1;
  logic signed [ces_pkg::COORD_W-1:0]     smoothed_y1;
  logic signed [ces_pkg::COORD_W-1:0]     smoothed_x2;
  logic signed [ces_pkg::COORD_W-1:0]     smoothed_y2;
  logic signed [ces_pkg::COORD_W-1:0]     smoothed_x3;
  logic signed [ces_pkg::COORD_W-1:0]     smoothed_y3;
  logic                                   history_restarted;

  modport source (
    output valid,
    output smoothed_x0, smoothed_y0, smoothed_x1, smoothed_y1,
    output smoothed_x2, smoothed_y2, smoothed_x3, smoothed_y3,
    output history_restarted,
    input  ready
  );

  modport sink (
    input  valid,
    input  smoothed_x0, smoothed_y0, smoothed_x1, smoothed_y1,
    input  smoothed_x2, smoothed_y2, smoothed_x3, smoothed_y3,
    input  history_restarted,
    output ready
  );
endinterface

[rtl/ces_front.sv]
module ces_front (
  input  logic             clk,
  input  logic             rst_n,
  input  ces_pkg::cfg_t    cfg,
  ces_in_if.sink           in_ch,
  input  logic             q_full,
  output logic             push,
  output ces_pkg::entry_t  push_entry
);

  logic                          hist_valid_r, hist_valid_nxt;
  logic [ces_pkg::FRAME_W-1:0]   last_frame_r, last_frame_nxt;
  logic [ces_pkg::FRAME_W-1:0]   delta;
  logic                          restart;

  assign in_ch.ready = !q_full;
  assign push        = in_ch.valid && !q_full;

  assign delta   = in_ch.frame_number - last_frame_r;
  assign restart = !hist_valid_r || (in_ch.frame_number <= last_frame_r) ||
                   (delta > {{(ces_pkg::FRAME_W-ces_pkg::GAP_W){1'b0}}, cfg.gap});

  // coordinates in x0,y0,...,y3 order
  always_comb begin
    push_entry.coords[0] = in_ch.corner_x0;
    push_entry.coords[1] = in_ch.corner_y0;
    push_entry.coords[2] = in_ch.corner_x1;
    push_entry.coords[3] = in_ch.corner_y1;
    push_entry.coords[4] = in_ch.corner_x2;
    push_entry.coords[5] = in_ch.corner_y2;
    push_entry.coords[6] = in_ch.corner_x3;
    push_entry.coords[7] = in_ch.corner_y3;
    hist_valid_nxt       = hist_valid_r;
    last_frame_nxt       = last_frame_r;
    priority if (!in_ch.corners_present) begin
      push_entry.mode      = ces_pkg::MODE_PASS;
      push_entry.restarted = 1'b1;
      hist_valid_nxt       = 1'b0;
      last_frame_nxt       = '0;
    end else if (!cfg.enable) begin
      push_entry.mode      = ces_pkg::MODE_PASS;
      push_entry.restarted = 1'b0;
    end else begin
      push_entry.mode      = restart ? ces_pkg::MODE_LOAD : ces_pkg::MODE_UPDATE;
      push_entry.restarted = restart;
      hist_valid_nxt       = 1'b1;
      last_frame_nxt       = in_ch.frame_number;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist_valid_r <= 1'b0;
      last_frame_r <= '0;
    end else if (push) begin
      hist_valid_r <= hist_valid_nxt;
      last_frame_r <= last_frame_nxt;
    end
  end

endmodule

[rtl/ces_queue.sv]
module ces_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  ces_pkg::entry_t  push_entry,
  input  logic             pop,
  output ces_pkg::entry_t  head,
  output logic             full,
  output logic             empty
);

  ces_pkg::entry_t              mem [ces_pkg::QUEUE_DEPTH];
  logic [ces_pkg::QPTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [ces_pkg::QCNT_W-1:0]   count_r;

  assign full  = (count_r == ces_pkg::QCNT_W'(ces_pkg::QUEUE_DEPTH));
  assign empty = (count_r == '0);
  assign head  = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule

[rtl/ces_back.sv]
module ces_back (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic [ces_pkg::ALPHA_W-1:0]   alpha,
  input  logic                          q_empty,
  input  ces_pkg::entry_t               head,
  output logic                          pop,
  ces_out_if.source                     out_ch
);

  localparam int DIFF_W = ces_pkg::HIST_W + 1;
  localparam int MUL_W  = DIFF_W + ces_pkg::ALPHA_W + 1;
  localparam int SUM_W  = ces_pkg::HIST_W + 1;

  ces_pkg::hist_t                        hist_r   [ces_pkg::NUM_COORDS];
  ces_pkg::hist_t                        hist_nxt [ces_pkg::NUM_COORDS];
  ces_pkg::coord_t                       res_nxt  [ces_pkg::NUM_COORDS];
  ces_pkg::coord_t                       res_r    [ces_pkg::NUM_COORDS];
  logic                                  restarted_r;
  logic                                  out_valid_r;
  logic signed [ces_pkg::ALPHA_W:0]      alpha_s;

  // alpha above 1.0 saturates
  assign alpha_s = (alpha > ces_pkg::ALPHA_ONE) ? {1'b0, ces_pkg::ALPHA_ONE} : {1'b0, alpha};
  assign pop     = !q_empty && (!out_valid_r || out_ch.ready);

  for (genvar i = 0; i < ces_pkg::NUM_COORDS; i++) begin : g_lane
    ces_pkg::hist_t          x20;
    logic signed [DIFF_W-1:0] diff;
    logic signed [MUL_W-1:0]  prod;
    logic signed [MUL_W-1:0]  prod_rnd;
    ces_pkg::hist_t          upd;
    logic signed [SUM_W-1:0]  out_rnd;
    logic signed [SUM_W-ces_pkg::FRAC_SHIFT-1:0] out_q;

    assign x20      = {head.coords[i], {ces_pkg::FRAC_SHIFT{1'b0}}};
    assign diff     = {x20[ces_pkg::HIST_W-1], x20} - {hist_r[i][ces_pkg::HIST_W-1], hist_r[i]};
    assign prod     = diff * alpha_s;
    assign prod_rnd = prod + MUL_W'(32'sd32768);
    // step stays in range, so modulo-2^32 accumulate is exact
    assign upd      = hist_r[i] + prod_rnd[ces_pkg::FRAC_SHIFT +: ces_pkg::HIST_W];

    always_comb begin
      unique case (head.mode)
        ces_pkg::MODE_LOAD:   hist_nxt[i] = x20;
        ces_pkg::MODE_UPDATE: hist_nxt[i] = upd;
        default:              hist_nxt[i] = hist_r[i];
      endcase
    end

    assign out_rnd = {hist_nxt[i][ces_pkg::HIST_W-1], hist_nxt[i]} + SUM_W'(32'sd32768);
    assign out_q   = out_rnd[SUM_W-1:ces_pkg::FRAC_SHIFT];

    always_comb begin
      priority if (head.mode == ces_pkg::MODE_PASS) begin
        res_nxt[i] = head.coords[i];
      end else if (out_q[SUM_W-ces_pkg::FRAC_SHIFT-1] != out_q[ces_pkg::COORD_W-1]) begin
        res_nxt[i] = out_q[SUM_W-ces_pkg::FRAC_SHIFT-1] ? 16'sh8000 : 16'sh7fff;
      end else begin
        res_nxt[i] = out_q[ces_pkg::COORD_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (pop && (head.mode != ces_pkg::MODE_PASS)) begin
        hist_r[i] <= hist_nxt[i];
      end
      if (pop) begin
        res_r[i] <= res_nxt[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      restarted_r <= head.restarted;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (pop) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.smoothed_x0       = res_r[0];
  assign out_ch.smoothed_y0       = res_r[1];
  assign out_ch.smoothed_x1       = res_r[2];
  assign out_ch.smoothed_y1       = res_r[3];
  assign out_ch.smoothed_x2       = res_r[4];
  assign out_ch.smoothed_y2       = res_r[5];
  assign out_ch.smoothed_x3       = res_r[6];
  assign out_ch.smoothed_y3       = res_r[7];
  assign out_ch.history_restarted = restarted_r;

endmodule

[rtl/corner_ema_smoother.sv]
// path: an item accepted by the front is written into the queue, then filtered from the
// queue head into the output register
// throughput: one item per cycle while the output is not stalled, through the multiply-add of each lane
// reset: synchronous active-low rst_n restores register defaults, empties the queue
// and marks the filter history invalid; no clearing pass is needed
module corner_ema_smoother (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [ces_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [ces_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  ces_in_if.sink                           in_ch,
  ces_out_if.source                        out_ch
);

  // configuration registers; the user must write them only while idle, the block does not enforce it
  logic                            enable_r;
  logic [ces_pkg::ALPHA_W-1:0]     alpha_r;
  logic [ces_pkg::GAP_W-1:0]       gap_r;
  ces_pkg::cfg_t                   cfg;

  // front to queue to back
  logic                            push;
  logic                            pop;
  logic                            q_full;
  logic                            q_empty;
  ces_pkg::entry_t                 push_entry;
  ces_pkg::entry_t                 head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r <= ces_pkg::ENABLE_RST;
      alpha_r  <= ces_pkg::ALPHA_RST;
      gap_r    <= ces_pkg::GAP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ces_pkg::REG_ENABLE: enable_r <= cfg_wdata[0];
        ces_pkg::REG_ALPHA:  alpha_r  <= cfg_wdata[ces_pkg::ALPHA_W-1:0];
        ces_pkg::REG_GAP:    gap_r    <= cfg_wdata[ces_pkg::GAP_W-1:0];
        default:             ;  // unused index, write dropped
      endcase
    end
  end

  assign cfg.enable = enable_r;
  assign cfg.alpha  = alpha_r;
  assign cfg.gap    = gap_r;

  // front: handshake, restart decision and frame bookkeeping, in arrival order
  ces_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_ch      (in_ch),
    .q_full     (q_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // two-entry queue lets the front keep taking items while the output stalls
  ces_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .full       (q_full),
    .empty      (q_empty)
  );

  // back: per-coordinate history and ema lanes, registered result
  ces_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .alpha   (alpha_r),
    .q_empty (q_empty),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule
